// ===== hw/rtl/psm_pkg.sv =====
package psm_pkg;

    localparam int NORM_BITS     = 31;
    localparam int ROOT_W        = NORM_BITS + 1;
    localparam int RAD_W         = 2 * ROOT_W;
    localparam int OUT_WIDTH     = 48;
    localparam int LIGHT_W_WIDTH = 32;
    localparam int NUM_COLS      = 4;

    typedef logic [1:0] t_col;

    localparam logic signed [LIGHT_W_WIDTH-1:0] LIGHT_W_RESET = 32'sd65536;
    localparam t_col COL_LAST = 2'd3;

endpackage

// ===== hw/rtl/psm_sqrt.sv =====
module psm_sqrt import psm_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [RAD_W-1:0]  i_radicand,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int REM_W = ROOT_W + 3;

    logic              r_v    [1:ROOT_W];
    logic [RAD_W-1:0]  r_x    [1:ROOT_W];
    logic [REM_W-1:0]  r_rem  [1:ROOT_W];
    logic [ROOT_W-1:0] r_root [1:ROOT_W];
    logic [SIDE_W-1:0] r_side [1:ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              v_in;
        logic [RAD_W-1:0]  x_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SIDE_W-1:0] side_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign x_in    = i_radicand;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k];
            assign x_in    = r_x[k];
            assign rem_in  = r_rem[k];
            assign root_in = r_root[k];
            assign side_in = r_side[k];
        end

        always_comb begin
            rem_sh = {rem_in[REM_W-3:0], x_in[RAD_W-1-2*k -: 2]};
            trial  = {1'b0, root_in, 2'b01};
            ge     = (rem_sh >= trial);
            n_rem  = ge ? (rem_sh - trial) : rem_sh;
            n_root = {root_in[ROOT_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[k+1]    <= x_in;
            r_rem[k+1]  <= n_rem;
            r_root[k+1] <= n_root;
            r_side[k+1] <= side_in;
        end
    end

    assign o_valid = r_v[ROOT_W];
    assign o_root  = r_root[ROOT_W];
    assign o_side  = r_side[ROOT_W];

endmodule

// ===== hw/rtl/psm_div.sv =====
module psm_div import psm_pkg::*; #(
    parameter int SIDE_W = 1,
    parameter int FRAC   = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [2:0][NORM_BITS-1:0]  i_mag,
    input  logic [ROOT_W-1:0]          i_len,
    input  logic [SIDE_W-1:0]          i_side,
    output logic                       o_valid,
    output logic [2:0][FRAC:0]         o_quot,
    output logic [SIDE_W-1:0]          o_side
);

    localparam int QW    = FRAC + 1;
    localparam int CMP_W = ROOT_W + QW;

    logic                    r_v    [1:QW];
    logic [2:0][CMP_W-1:0]   r_rem  [1:QW];
    logic [2:0][QW-1:0]      r_q    [1:QW];
    logic [ROOT_W-1:0]       r_len  [1:QW];
    logic [SIDE_W-1:0]       r_side [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic                  v_in;
        logic [2:0][CMP_W-1:0] rem_in;
        logic [2:0][QW-1:0]    q_in;
        logic [ROOT_W-1:0]     len_in;
        logic [SIDE_W-1:0]     side_in;
        logic [CMP_W-1:0]      trial;
        logic [2:0][CMP_W-1:0] n_rem;
        logic [2:0][QW-1:0]    n_q;

        if (k == 0) begin : g_first
            always_comb begin
                for (int j = 0; j < 3; j++) begin
                    rem_in[j] = CMP_W'({i_mag[j], {FRAC{1'b0}}})
                              + CMP_W'(i_len >> 1);
                end
            end
            assign v_in    = i_valid;
            assign q_in    = '0;
            assign len_in  = i_len;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k];
            assign rem_in  = r_rem[k];
            assign q_in    = r_q[k];
            assign len_in  = r_len[k];
            assign side_in = r_side[k];
        end

        always_comb begin
            trial = CMP_W'(len_in) << B;
            for (int j = 0; j < 3; j++) begin
                n_q[j] = q_in[j];
                if (rem_in[j] >= trial) begin
                    n_rem[j]  = rem_in[j] - trial;
                    n_q[j][B] = 1'b1;
                end else begin
                    n_rem[j] = rem_in[j];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= n_rem;
            r_q[k+1]    <= n_q;
            r_len[k+1]  <= len_in;
            r_side[k+1] <= side_in;
        end
    end

    assign o_valid = r_v[QW];
    assign o_quot  = r_q[QW];
    assign o_side  = r_side[QW];

endmodule

// ===== hw/rtl/planar_shadow_matrix.sv =====
// One start beat yields four result beats, columns 0 to 3 on consecutive cycles.
// A start beat is accepted only while o_busy is low, pacing items to the one-column-wide result port.
// Synchronous active-low reset clears all valid bits and sets light_w to 1.0.
// The receiver cannot stall; results are never held back.
module planar_shadow_matrix import psm_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_cfg_we,
    input  logic [LIGHT_W_WIDTH-1:0]       i_cfg_data,
    input  logic signed [COORD_WIDTH-1:0]  i_p0_x,
    input  logic signed [COORD_WIDTH-1:0]  i_p0_y,
    input  logic signed [COORD_WIDTH-1:0]  i_p0_z,
    input  logic signed [COORD_WIDTH-1:0]  i_p1_x,
    input  logic signed [COORD_WIDTH-1:0]  i_p1_y,
    input  logic signed [COORD_WIDTH-1:0]  i_p1_z,
    input  logic signed [COORD_WIDTH-1:0]  i_p2_x,
    input  logic signed [COORD_WIDTH-1:0]  i_p2_y,
    input  logic signed [COORD_WIDTH-1:0]  i_p2_z,
    input  logic signed [COORD_WIDTH-1:0]  i_light_x,
    input  logic signed [COORD_WIDTH-1:0]  i_light_y,
    input  logic signed [COORD_WIDTH-1:0]  i_light_z,
    output logic                           o_valid,
    output logic [1:0]                     o_column,
    output logic signed [OUT_WIDTH-1:0]    o_row0_entry,
    output logic signed [OUT_WIDTH-1:0]    o_row1_entry,
    output logic signed [OUT_WIDTH-1:0]    o_row2_entry,
    output logic signed [OUT_WIDTH-1:0]    o_row3_entry,
    output logic                           o_degenerate,
    output logic                           o_last
);

    localparam int CW     = COORD_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int VW     = CW + 1;
    localparam int PRW    = 2 * VW;
    localparam int NW     = PRW + 1;
    localparam int MW     = PRW;
    localparam int SHW    = $clog2(MW);
    localparam int NB     = NORM_BITS;
    localparam int QW     = F + 1;
    localparam int CKW    = F + 2;
    localparam int LW     = (CW > LIGHT_W_WIDTH) ? CW : LIGHT_W_WIDTH;
    localparam int SW     = CKW + CW + 2;
    localparam int DW     = SW + 2 - F;
    localparam int CDW    = (CKW > DW) ? CKW : DW;
    localparam int TW     = CDW + LW + 2;
    localparam int EW     = TW + 1;
    localparam int XW     = (EW + 1 > OUT_WIDTH + F) ? EW + 1 : OUT_WIDTH + F;
    localparam int SIDE_A = 6 * CW;
    localparam int SIDE_N = SIDE_A + 3;
    localparam int SIDE_D = SIDE_N + 1;
    localparam int SIDE_Q = SIDE_D + 3 * NB;

    localparam logic [1:0] GAP = 2'(NUM_COLS - 1);
    localparam logic signed [SW+1:0] D_HALF = (SW+2)'(1) << (F - 1);
    localparam logic signed [XW-1:0] E_HALF = XW'(1) << (F - 1);
    localparam logic signed [OUT_WIDTH-1:0] SAT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic signed [OUT_WIDTH-1:0] SAT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    logic accept;

    // Configuration and input pacing.
    logic signed [LIGHT_W_WIDTH-1:0] r_light_w;
    logic [1:0]                      r_gap;

    assign o_busy = (r_gap != 2'd0);
    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_w <= LIGHT_W_RESET;
            r_gap     <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_light_w <= i_cfg_data;
            end
            if (accept) begin
                r_gap <= GAP;
            end else if (r_gap != 2'd0) begin
                r_gap <= r_gap - 2'd1;
            end
        end
    end

    // Edge vectors.
    logic                 r_s1_v;
    logic signed [VW-1:0] r_v1 [3];
    logic signed [VW-1:0] r_v2 [3];
    logic [SIDE_A-1:0]    r_s1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v1[0]   <= VW'(i_p0_x) - VW'(i_p1_x);
        r_v1[1]   <= VW'(i_p0_y) - VW'(i_p1_y);
        r_v1[2]   <= VW'(i_p0_z) - VW'(i_p1_z);
        r_v2[0]   <= VW'(i_p1_x) - VW'(i_p2_x);
        r_v2[1]   <= VW'(i_p1_y) - VW'(i_p2_y);
        r_v2[2]   <= VW'(i_p1_z) - VW'(i_p2_z);
        r_s1_side <= {i_p2_x, i_p2_y, i_p2_z, i_light_x, i_light_y, i_light_z};
    end

    // Cross product terms.
    logic                  r_s2_v;
    logic signed [PRW-1:0] r_pa [3];
    logic signed [PRW-1:0] r_pb [3];
    logic [SIDE_A-1:0]     r_s2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa[0]   <= r_v1[1] * r_v2[2];
        r_pb[0]   <= r_v1[2] * r_v2[1];
        r_pa[1]   <= r_v1[2] * r_v2[0];
        r_pb[1]   <= r_v1[0] * r_v2[2];
        r_pa[2]   <= r_v1[0] * r_v2[1];
        r_pb[2]   <= r_v1[1] * r_v2[0];
        r_s2_side <= r_s1_side;
    end

    logic                 r_s3_v;
    logic signed [NW-1:0] r_n [3];
    logic [SIDE_A-1:0]    r_s3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_n[k] <= NW'(r_pa[k]) - NW'(r_pb[k]);
        end
        r_s3_side <= r_s2_side;
    end

    // Normalization: shift all three magnitudes by the amount that puts the
    // leading one of their OR at the top.
    logic              r_nm_v    [0:SHW];
    logic [MW-1:0]     r_nm      [0:SHW][3];
    logic [MW-1:0]     r_nm_or   [0:SHW];
    logic [SIDE_N-1:0] r_nm_side [0:SHW];
    logic [MW-1:0]     mag       [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag[k] = r_n[k][NW-1] ? MW'(-r_n[k]) : MW'(r_n[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm_v[0] <= 1'b0;
        end else begin
            r_nm_v[0] <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_nm[0][k] <= mag[k];
        end
        r_nm_or[0]   <= mag[0] | mag[1] | mag[2];
        r_nm_side[0] <= {r_n[0][NW-1], r_n[1][NW-1], r_n[2][NW-1], r_s3_side};
    end

    for (genvar s = 0; s < SHW; s++) begin : g_norm
        localparam int A = 1 << (SHW - 1 - s);
        logic zero;

        assign zero = (r_nm_or[s][MW-1 -: A] == '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nm_v[s+1] <= 1'b0;
            end else begin
                r_nm_v[s+1] <= r_nm_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            for (int k = 0; k < 3; k++) begin
                r_nm[s+1][k] <= zero ? (r_nm[s][k] << A) : r_nm[s][k];
            end
            r_nm_or[s+1]   <= zero ? (r_nm_or[s] << A) : r_nm_or[s];
            r_nm_side[s+1] <= r_nm_side[s];
        end
    end

    // Squares and their sum.
    logic                r_s5_v;
    logic [2*NB-1:0]     r_sq [3];
    logic [NB-1:0]       r_s5_m [3];
    logic [SIDE_D-1:0]   r_s5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else begin
            r_s5_v <= r_nm_v[SHW];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_sq[k]   <= r_nm[SHW][k][MW-1 -: NB] * r_nm[SHW][k][MW-1 -: NB];
            r_s5_m[k] <= r_nm[SHW][k][MW-1 -: NB];
        end
        r_s5_side <= {~r_nm_or[SHW][MW-1], r_nm_side[SHW]};
    end

    logic              r_s6_v;
    logic [RAD_W-1:0]  r_sum;
    logic [SIDE_Q-1:0] r_s6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_v <= 1'b0;
        end else begin
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum     <= RAD_W'(r_sq[0]) + RAD_W'(r_sq[1]) + RAD_W'(r_sq[2]);
        r_s6_side <= {r_s5_m[0], r_s5_m[1], r_s5_m[2], r_s5_side};
    end

    // Length and the three divisions.
    logic                     sq_v;
    logic [ROOT_W-1:0]        sq_root;
    logic [SIDE_Q-1:0]        sq_side;
    logic [2:0][NB-1:0]       dv_mag;
    logic                     dv_v;
    logic [2:0][QW-1:0]       dv_q;
    logic [SIDE_D-1:0]        dv_side;

    psm_sqrt #(
        .SIDE_W (SIDE_Q)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_s6_v),
        .i_radicand (r_sum),
        .i_side     (r_s6_side),
        .o_valid    (sq_v),
        .o_root     (sq_root),
        .o_side     (sq_side)
    );

    assign dv_mag[0] = sq_side[SIDE_Q-1 -: NB];
    assign dv_mag[1] = sq_side[SIDE_Q-1-NB -: NB];
    assign dv_mag[2] = sq_side[SIDE_Q-1-2*NB -: NB];

    psm_div #(
        .SIDE_W (SIDE_D),
        .FRAC   (F)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_v),
        .i_mag   (dv_mag),
        .i_len   (sq_root),
        .i_side  (sq_side[SIDE_D-1:0]),
        .o_valid (dv_v),
        .o_quot  (dv_q),
        .o_side  (dv_side)
    );

    // Signed unit normal.
    logic                  r_c1_v;
    logic signed [CKW-1:0] r_c1_c [3];
    logic signed [CW-1:0]  r_c1_p [3];
    logic signed [LW-1:0]  r_c1_l [3];
    logic                  r_c1_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_v <= 1'b0;
        end else begin
            r_c1_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_c1_c[k] <= dv_side[SIDE_N-1-k] ? -$signed({1'b0, dv_q[k]})
                                             : $signed({1'b0, dv_q[k]});
            r_c1_p[k] <= $signed(dv_side[SIDE_A-1-k*CW -: CW]);
            r_c1_l[k] <= LW'($signed(dv_side[3*CW-1-k*CW -: CW]));
        end
        r_c1_dg <= dv_side[SIDE_D-1];
    end

    // Plane offset D.
    logic                     r_d1_v;
    logic signed [CKW+CW-1:0] r_dp [3];
    logic signed [CKW-1:0]    r_d1_c [3];
    logic signed [LW-1:0]     r_d1_l [3];
    logic                     r_d1_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_v <= 1'b0;
        end else begin
            r_d1_v <= r_c1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_dp[k] <= r_c1_c[k] * r_c1_p[k];
        end
        r_d1_c  <= r_c1_c;
        r_d1_l  <= r_c1_l;
        r_d1_dg <= r_c1_dg;
    end

    logic                  r_d2_v;
    logic signed [SW-1:0]  r_s;
    logic signed [CKW-1:0] r_d2_c [3];
    logic signed [LW-1:0]  r_d2_l [3];
    logic                  r_d2_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d2_v <= 1'b0;
        end else begin
            r_d2_v <= r_d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s     <= SW'(r_dp[0]) + SW'(r_dp[1]) + SW'(r_dp[2]);
        r_d2_c  <= r_d1_c;
        r_d2_l  <= r_d1_l;
        r_d2_dg <= r_d1_dg;
    end

    logic                  r_d3_v;
    logic signed [DW-1:0]  r_d;
    logic signed [CKW-1:0] r_d3_c [3];
    logic signed [LW-1:0]  r_d3_l [3];
    logic                  r_d3_dg;
    logic signed [SW+1:0]  d_round;
    logic signed [SW+1:0]  d_shift;

    always_comb begin
        d_round = -(SW+2)'(r_s) + D_HALF;
        d_shift = d_round >>> F;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d3_v <= 1'b0;
        end else begin
            r_d3_v <= r_d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d     <= d_shift[DW-1:0];
        r_d3_c  <= r_d2_c;
        r_d3_l  <= r_d2_l;
        r_d3_dg <= r_d2_dg;
    end

    // Dot product of plane and light.
    logic                     r_t1_v;
    logic signed [CKW+LW-1:0] r_tp [3];
    logic signed [DW+LW-1:0]  r_tw;
    logic signed [CKW-1:0]    r_t1_c [3];
    logic signed [DW-1:0]     r_t1_d;
    logic signed [LW-1:0]     r_t1_l [3];
    logic                     r_t1_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_v <= 1'b0;
        end else begin
            r_t1_v <= r_d3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_tp[k] <= r_d3_c[k] * r_d3_l[k];
        end
        r_tw    <= r_d * LW'(r_light_w);
        r_t1_c  <= r_d3_c;
        r_t1_d  <= r_d;
        r_t1_l  <= r_d3_l;
        r_t1_dg <= r_d3_dg;
    end

    logic                  r_t2_v;
    logic signed [TW-1:0]  r_temp;
    logic signed [CKW-1:0] r_t2_c [3];
    logic signed [DW-1:0]  r_t2_d;
    logic signed [LW-1:0]  r_t2_l [3];
    logic                  r_t2_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t2_v <= 1'b0;
        end else begin
            r_t2_v <= r_t1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_temp  <= TW'(r_tp[0]) + TW'(r_tp[1]) + TW'(r_tp[2]) + TW'(r_tw);
        r_t2_c  <= r_t1_c;
        r_t2_d  <= r_t1_d;
        r_t2_l  <= r_t1_l;
        r_t2_dg <= r_t1_dg;
    end

    // Column sequencer: holds one matrix and walks its four columns.
    logic                  r_em_act;
    t_col                  r_em_col;
    logic signed [CDW-1:0] r_h_c [4];
    logic signed [LW-1:0]  r_h_l [3];
    logic signed [TW-1:0]  r_h_temp;
    logic                  r_h_dg;
    logic signed [LW-1:0]  col_l;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_act <= 1'b0;
            r_em_col <= '0;
        end else if (r_t2_v) begin
            r_em_act <= 1'b1;
            r_em_col <= '0;
        end else if (r_em_act) begin
            r_em_col <= r_em_col + 2'd1;
            if (r_em_col == COL_LAST) begin
                r_em_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_t2_v) begin
            for (int k = 0; k < 3; k++) begin
                r_h_c[k] <= CDW'(r_t2_c[k]);
            end
            r_h_c[3] <= CDW'(r_t2_d);
            r_h_l    <= r_t2_l;
            r_h_temp <= r_temp;
            r_h_dg   <= r_t2_dg;
        end
    end

    always_comb begin
        case (r_em_col)
            2'd0:    col_l = r_h_l[0];
            2'd1:    col_l = r_h_l[1];
            2'd2:    col_l = r_h_l[2];
            default: col_l = LW'(r_light_w);
        endcase
    end

    logic                     r_e1_v;
    logic signed [CDW+LW-1:0] r_e1_p [4];
    logic signed [TW-1:0]     r_e1_temp;
    t_col                     r_e1_col;
    logic                     r_e1_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
        end else begin
            r_e1_v <= r_em_act;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_e1_p[i] <= r_h_c[i] * col_l;
        end
        r_e1_temp <= r_h_temp;
        r_e1_col  <= r_em_col;
        r_e1_dg   <= r_h_dg;
    end

    logic                 r_e2_v;
    logic signed [XW-1:0] r_e2 [4];
    t_col                 r_e2_col;
    logic                 r_e2_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_v <= 1'b0;
        end else begin
            r_e2_v <= r_e1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_e2[i] <= ((r_e1_col == t_col'(i)) ? XW'(r_e1_temp) : XW'(0))
                     - XW'(r_e1_p[i]) + E_HALF;
        end
        r_e2_col <= r_e1_col;
        r_e2_dg  <= r_e1_dg;
    end

    // Rounding shift and saturation to the output width; a degenerate result gives zero entries.
    logic signed [XW-1:0]        e_sh  [4];
    logic [XW-OUT_WIDTH:0]       e_hi  [4];
    logic signed [OUT_WIDTH-1:0] n_row [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            e_sh[i] = r_e2[i] >>> F;
            e_hi[i] = e_sh[i][XW-1:OUT_WIDTH-1];
            if (r_e2_dg) begin
                n_row[i] = '0;
            end else if ((&e_hi[i]) || !(|e_hi[i])) begin
                n_row[i] = e_sh[i][OUT_WIDTH-1:0];
            end else if (e_sh[i][XW-1]) begin
                n_row[i] = SAT_MIN;
            end else begin
                n_row[i] = SAT_MAX;
            end
        end
    end

    logic                        r_o_v;
    t_col                        r_o_col;
    logic signed [OUT_WIDTH-1:0] r_o_row [4];
    logic                        r_o_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= r_e2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_row <= n_row;
        r_o_col <= r_e2_col;
        r_o_dg  <= r_e2_dg;
    end

    assign o_valid      = r_o_v;
    assign o_column     = r_o_col;
    assign o_row0_entry = r_o_row[0];
    assign o_row1_entry = r_o_row[1];
    assign o_row2_entry = r_o_row[2];
    assign o_row3_entry = r_o_row[3];
    assign o_degenerate = r_o_dg;
    assign o_last       = (r_o_col == COL_LAST);

endmodule
